FILE: sv/bmp_stream_decoder_unit_macros.svh
// Assertion macros used by the decoder's command queue.
`ifndef BMP_STREAM_DECODER_UNIT_MACROS_SVH
`define BMP_STREAM_DECODER_UNIT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define BSD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks an implication at every rising clock edge outside reset.
`define BSD_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

`endif

FILE: sv/bsd_pkg.sv
// Shared types and constants of the BMP stream decoder.
`timescale 1ns / 1ps
package bsd_pkg;
  localparam logic [1:0] KIND_INFO = 2'd0;
  localparam logic [1:0] KIND_PAL  = 2'd1;
  localparam logic [1:0] KIND_PIX  = 2'd2;
  localparam logic [1:0] KIND_ERR  = 2'd3;

  localparam logic [7:0] ERR_MAGIC     = 8'd0;
  localparam logic [7:0] ERR_COMP      = 8'd1;
  localparam logic [7:0] ERR_DEPTH     = 8'd2;
  localparam logic [7:0] ERR_SIZE      = 8'd3;
  localparam logic [7:0] ERR_TRUNCATED = 8'd4;
  localparam logic [7:0] ERR_OFFSET    = 8'd5;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_EXP4  = 2'd1;
  localparam logic [1:0] MODE_EXP1  = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] row;
    logic [12:0] col;
    logic [7:0]  value;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [11:0] width;
    logic [11:0] height;
    logic [5:0]  depth_out;
    logic [8:0]  color_count;
    logic        last;
  } res_t;

  typedef struct packed {
    res_t       res;
    logic [3:0] cnt;
    logic [1:0] mode;
    logic       tail_err;
  } cmd_t;
endpackage

FILE: sv/bsd_if.sv
// Stream interfaces of the decoder: byte input and result output.
`timescale 1ns / 1ps
interface bsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_file;
  modport source (output valid, data_byte, end_of_file, input ready);
  modport sink (input valid, data_byte, end_of_file, output ready);
endinterface

interface bsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [10:0] row;
  logic [12:0] col;
  logic [7:0]  value;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [11:0] width;
  logic [11:0] height;
  logic [5:0]  depth_out;
  logic [8:0]  color_count;
  logic        last;
  modport source (output valid, kind, row, col, value, red, green, blue, width, height,
                  depth_out, color_count, last, input ready);
  modport sink (input valid, kind, row, col, value, red, green, blue, width, height,
                depth_out, color_count, last, output ready);
endinterface

FILE: sv/bmp_stream_decoder_unit.sv
// Top level of the streaming uncompressed BMP decoder.
// The input channel takes one file byte per beat, with end_of_file on the last byte.
// The result channel gives info, palette, pixel and error beats; last marks the final
// beat caused by one input byte.
// The parser takes one byte per cycle unless the queue is full and writes at most one
// command into a four-entry queue; the sequencer makes one to eight beats per command.
// The first beat of a byte is registered in the command queue, then in the output register.
// Throughput: one byte per cycle for 8, 24 and 32 bit images and headers; 4 and 1 bit
// images give up to two and eight beats per byte, set by the one-beat-per-cycle
// sequencer, and the input waits when the queue is full.
// A stalled receiver holds the output register; the queue absorbs up to four commands,
// then the input ready drops.
// Reset (rst_n low, synchronous) returns the parser to the file header and empties
// the queue and output register. After an error or a complete image, bytes are
// taken and dropped until the next reset.
`timescale 1ns / 1ps
module bmp_stream_decoder_unit #(
  parameter int MAX_DIM     = 2048,
  parameter int PALETTE_MAX = 256
) (
  input logic       clk,
  input logic       rst_n,
  bsd_in_if.sink    in_bus,
  bsd_out_if.source out_bus
);
  import bsd_pkg::*;

  logic q_not_full;
  logic q_not_empty;
  logic push;
  logic pop;
  cmd_t wcmd;
  cmd_t rcmd;
  res_t res;

  bsd_front #(.MAX_DIM(MAX_DIM), .PALETTE_MAX(PALETTE_MAX)) u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_bus.valid), .in_ready(in_bus.ready),
    .in_data(in_bus.data_byte), .in_eof(in_bus.end_of_file),
    .cmd_ready(q_not_full), .cmd_push(push), .cmd(wcmd)
  );

  bsd_cmd_fifo u_fifo (
    .clk(clk), .rst_n(rst_n),
    .push(push), .wdata(wcmd), .not_full(q_not_full),
    .pop(pop), .not_empty(q_not_empty), .rdata(rcmd)
  );

  bsd_back u_back (
    .clk(clk), .rst_n(rst_n),
    .cmd_valid(q_not_empty), .cmd(rcmd), .cmd_pop(pop),
    .out_valid(out_bus.valid), .out_ready(out_bus.ready), .out_res(res)
  );

  assign out_bus.kind        = res.kind;
  assign out_bus.row         = res.row;
  assign out_bus.col         = res.col;
  assign out_bus.value       = res.value;
  assign out_bus.red         = res.red;
  assign out_bus.green       = res.green;
  assign out_bus.blue        = res.blue;
  assign out_bus.width       = res.width;
  assign out_bus.height      = res.height;
  assign out_bus.depth_out   = res.depth_out;
  assign out_bus.color_count = res.color_count;
  assign out_bus.last        = res.last;
endmodule

FILE: sv/bsd_front.sv
// Front end: parses the byte stream and issues one command per productive byte.
`timescale 1ns / 1ps
module bsd_front #(
  parameter int MAX_DIM     = 2048,
  parameter int PALETTE_MAX = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_data,
  input  logic          in_eof,
  input  logic          cmd_ready,
  output logic          cmd_push,
  output bsd_pkg::cmd_t cmd
);
  import bsd_pkg::*;

  localparam int DW  = $clog2(MAX_DIM + 1);
  localparam int RBW = $clog2(4 * MAX_DIM + 4);

  typedef enum logic [2:0] {
    PH_FHDR, PH_IHDR, PH_SKIP, PH_PAL, PH_GAP, PH_PIX, PH_DONE, PH_ERR
  } phase_t;

  phase_t           ph_r, ph_nxt;
  logic [32:0]      fp_r, fp_nxt;
  logic [31:0]      shift_r, shift_nxt;
  logic [31:0]      offset_r, offset_nxt;
  logic [31:0]      hsize_r, hsize_nxt;
  logic [DW-1:0]    width_r, width_nxt;
  logic [DW-1:0]    height_r, height_nxt;
  logic             top_r, top_nxt;
  logic [5:0]       depth_r, depth_nxt;
  logic [8:0]       ptotal_r, ptotal_nxt;
  logic [8:0]       pidx_r, pidx_nxt;
  logic [1:0]       psub_r, psub_nxt;
  logic [7:0]       palb_r, palb_nxt;
  logic [7:0]       palg_r, palg_nxt;
  logic [DW-1:0]    srow_r, srow_nxt;
  logic [RBW-1:0]   rbyte_r, rbyte_nxt;
  logic [RBW-1:0]   srb_r, srb_nxt;
  logic [RBW-1:0]   padded_r, padded_nxt;
  logic             compbad_r, compbad_nxt;
  logic             sizebad_r, sizebad_nxt;
  logic [31:0]      cused_r, cused_nxt;

  logic             acc;
  logic             push;
  cmd_t             c;
  logic [31:0]      w;
  logic [31:0]      mag;
  logic [15:0]      bpp;
  logic [31:0]      ncol;
  logic [RBW+2:0]   srb_calc;
  logic [RBW+2:0]   base;
  logic [RBW+2:0]   diff;
  logic [RBW:0]     rb1;
  logic [31:0]      pos;

  assign in_ready = cmd_ready;
  assign acc      = in_valid && cmd_ready;
  assign pos      = fp_r[31:0];

  always_comb begin
    ph_nxt = ph_r; fp_nxt = fp_r; shift_nxt = shift_r; offset_nxt = offset_r;
    hsize_nxt = hsize_r; width_nxt = width_r; height_nxt = height_r; top_nxt = top_r;
    depth_nxt = depth_r; ptotal_nxt = ptotal_r; pidx_nxt = pidx_r; psub_nxt = psub_r;
    palb_nxt = palb_r; palg_nxt = palg_r; srow_nxt = srow_r; rbyte_nxt = rbyte_r;
    srb_nxt = srb_r; padded_nxt = padded_r; compbad_nxt = compbad_r;
    sizebad_nxt = sizebad_r; cused_nxt = cused_r;
    push = 1'b0;
    c = '0;
    c.cnt = 4'd1;
    c.mode = MODE_PLAIN;
    w = {in_data, shift_r[31:8]};
    mag = w[31] ? (~w + 32'd1) : w;
    bpp = w[31:16];
    ncol = (cused_r != 32'd0) ? cused_r : (32'd1 << depth_r);
    srb_calc = '0;
    base = '0;
    diff = '0;
    rb1 = {1'b0, rbyte_r} + 1'b1;
    if (acc) begin
      case (ph_r)
        PH_FHDR, PH_IHDR: begin
          if (ph_r == PH_FHDR && ((pos == 32'd0 && in_data != 8'h42) ||
                                  (pos == 32'd1 && in_data != 8'h4D))) begin
            push = 1'b1; c.res.kind = KIND_ERR; c.res.value = ERR_MAGIC; ph_nxt = PH_ERR;
          end else begin
            shift_nxt = w;
            case (pos)
              32'd13: begin
                offset_nxt = w;
                ph_nxt = PH_IHDR;
              end
              32'd17: hsize_nxt = w;
              32'd21: begin
                width_nxt = w[DW-1:0];
                if (w == 32'd0 || w > 32'(MAX_DIM)) sizebad_nxt = 1'b1;
              end
              32'd25: begin
                top_nxt = w[31];
                height_nxt = mag[DW-1:0];
                if (mag == 32'd0 || mag > 32'(MAX_DIM)) sizebad_nxt = 1'b1;
              end
              32'd29: begin
                depth_nxt = (bpp == 16'd1 || bpp == 16'd4 || bpp == 16'd8 ||
                             bpp == 16'd24 || bpp == 16'd32) ? bpp[5:0] : 6'd0;
              end
              32'd33: compbad_nxt = (w != 32'd0);
              32'd49: cused_nxt = w;
              32'd53: begin
                push = 1'b1;
                if (compbad_r) begin
                  c.res.kind = KIND_ERR; c.res.value = ERR_COMP; ph_nxt = PH_ERR;
                end else if (depth_r == 6'd0) begin
                  c.res.kind = KIND_ERR; c.res.value = ERR_DEPTH; ph_nxt = PH_ERR;
                end else if (sizebad_r ||
                             (depth_r <= 6'd8 && ncol > 32'(PALETTE_MAX))) begin
                  c.res.kind = KIND_ERR; c.res.value = ERR_SIZE; ph_nxt = PH_ERR;
                end else begin
                  c.res.kind = KIND_INFO;
                  c.res.width = 12'(width_r);
                  c.res.height = 12'(height_r);
                  c.res.depth_out = (depth_r <= 6'd8) ? 6'd8 : depth_r;
                  c.res.color_count = (depth_r <= 6'd8) ? ncol[8:0] : 9'd0;
                  ptotal_nxt = (depth_r <= 6'd8) ? ncol[8:0] : 9'd0;
                  hsize_nxt = (hsize_r > 32'd40) ? hsize_r - 32'd40 : 32'd0;
                  case (depth_r)
                    6'd1:    srb_calc = ((RBW+3)'(width_r) + (RBW+3)'(7)) >> 3;
                    6'd4:    srb_calc = ((RBW+3)'(width_r) + (RBW+3)'(1)) >> 1;
                    6'd8:    srb_calc = (RBW+3)'(width_r);
                    6'd24:   srb_calc = (RBW+3)'(width_r) * (RBW+3)'(3);
                    default: srb_calc = (RBW+3)'(width_r) << 2;
                  endcase
                  srb_nxt = srb_calc[RBW-1:0];
                  padded_nxt = (srb_calc[RBW-1:0] + RBW'(3)) & ~RBW'(3);
                  ph_nxt = PH_SKIP;
                end
              end
              default: ;
            endcase
          end
        end
        PH_SKIP: begin
          if (hsize_r != 32'd0) hsize_nxt = hsize_r - 32'd1;
        end
        PH_PAL: begin
          case (psub_r)
            2'd0: palb_nxt = in_data;
            2'd1: palg_nxt = in_data;
            2'd2: begin
              push = 1'b1;
              c.res.kind = KIND_PAL;
              c.res.col = 13'(pidx_r);
              c.res.red = in_data;
              c.res.green = palg_r;
              c.res.blue = palb_r;
            end
            default: pidx_nxt = pidx_r + 9'd1;
          endcase
          psub_nxt = psub_r + 2'd1;
        end
        PH_PIX: begin
          if (rbyte_r < srb_r) begin
            push = 1'b1;
            c.res.kind = KIND_PIX;
            c.res.row = top_r ? 11'(srow_r) : 11'(height_r - 1'b1 - srow_r);
            c.res.value = in_data;
            if (depth_r == 6'd4 || depth_r == 6'd1) begin
              base = (depth_r == 6'd4) ? ((RBW+3)'(rbyte_r) << 1) : ((RBW+3)'(rbyte_r) << 3);
              diff = (RBW+3)'(width_r) - base;
              c.res.col = base[12:0];
              c.mode = (depth_r == 6'd4) ? MODE_EXP4 : MODE_EXP1;
              if (depth_r == 6'd4) c.cnt = (diff >= 2) ? 4'd2 : diff[3:0];
              else c.cnt = (diff >= 8) ? 4'd8 : diff[3:0];
            end else begin
              c.res.col = 13'(rbyte_r);
            end
          end
          rbyte_nxt = rb1[RBW-1:0];
          if ({1'b0, srow_r} + 1'b1 >= {1'b0, height_r} && rb1 >= {1'b0, srb_r}) begin
            ph_nxt = PH_DONE;
          end else if (rb1 >= {1'b0, padded_r}) begin
            rbyte_nxt = '0;
            srow_nxt = srow_r + 1'b1;
          end
        end
        default: ;
      endcase
      if (!fp_r[32]) fp_nxt = fp_r + 33'd1;
      if (ph_nxt == PH_SKIP && hsize_nxt == 32'd0) begin
        ph_nxt = PH_PAL;
        pidx_nxt = '0;
        psub_nxt = '0;
      end
      if (ph_nxt == PH_PAL && pidx_nxt >= ptotal_nxt) begin
        if ({1'b0, offset_r} < fp_nxt) begin
          if (push) begin
            c.tail_err = 1'b1;
          end else begin
            push = 1'b1; c.res.kind = KIND_ERR; c.res.value = ERR_OFFSET;
          end
          ph_nxt = PH_ERR;
        end else begin
          ph_nxt = PH_GAP;
        end
      end
      if (ph_nxt == PH_GAP && fp_nxt == {1'b0, offset_r}) begin
        ph_nxt = PH_PIX;
        srow_nxt = '0;
        rbyte_nxt = '0;
      end
      if (in_eof && ph_nxt != PH_DONE && ph_nxt != PH_ERR) begin
        c = '0;
        c.cnt = 4'd1;
        c.mode = MODE_PLAIN;
        c.res.kind = KIND_ERR;
        c.res.value = ERR_TRUNCATED;
        push = 1'b1;
        ph_nxt = PH_ERR;
      end
    end
  end

  assign cmd_push = push;
  assign cmd      = c;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= PH_FHDR; fp_r <= '0; shift_r <= '0; offset_r <= '0; hsize_r <= '0;
      width_r <= '0; height_r <= '0; top_r <= 1'b0; depth_r <= '0; ptotal_r <= '0;
      pidx_r <= '0; psub_r <= '0; palb_r <= '0; palg_r <= '0; srow_r <= '0;
      rbyte_r <= '0; srb_r <= '0; padded_r <= '0; compbad_r <= 1'b0;
      sizebad_r <= 1'b0; cused_r <= '0;
    end else begin
      ph_r <= ph_nxt; fp_r <= fp_nxt; shift_r <= shift_nxt; offset_r <= offset_nxt;
      hsize_r <= hsize_nxt; width_r <= width_nxt; height_r <= height_nxt;
      top_r <= top_nxt; depth_r <= depth_nxt; ptotal_r <= ptotal_nxt;
      pidx_r <= pidx_nxt; psub_r <= psub_nxt; palb_r <= palb_nxt; palg_r <= palg_nxt;
      srow_r <= srow_nxt; rbyte_r <= rbyte_nxt; srb_r <= srb_nxt;
      padded_r <= padded_nxt; compbad_r <= compbad_nxt; sizebad_r <= sizebad_nxt;
      cused_r <= cused_nxt;
    end
  end
endmodule

FILE: sv/bsd_cmd_fifo.sv
// Short command queue between the parser and the result sequencer.
`timescale 1ns / 1ps
`include "bmp_stream_decoder_unit_macros.svh"
module bsd_cmd_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  bsd_pkg::cmd_t wdata,
  output logic          not_full,
  input  logic          pop,
  output logic          not_empty,
  output bsd_pkg::cmd_t rdata
);
  import bsd_pkg::*;

  cmd_t       mem_r [4];
  logic [1:0] wptr_r;
  logic [1:0] rptr_r;
  logic [2:0] count_r;

  assign not_full  = (count_r != 3'd4);
  assign not_empty = (count_r != 3'd0);
  assign rdata     = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wptr_r] <= wdata;
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 2'd1;
      if (pop) rptr_r <= rptr_r + 2'd1;
      count_r <= count_r + {2'd0, push} - {2'd0, pop};
    end
  end

  `BSD_ASSERT_IMP(a_no_overflow, push, not_full || pop, "Command queue overflow.")
  `BSD_ASSERT_IMP(a_no_underflow, pop, not_empty, "Command queue underflow.")
  `BSD_ASSERT(a_count_range, count_r <= 3'd4, "Command queue count out of range.")
  `BSD_ASSERT_IMP(a_cnt_nonzero, not_empty, rdata.cnt != 4'd0, "Queued command has no beats.")
endmodule

FILE: sv/bsd_back.sv
// Back end: expands queued commands into result beats behind an output register.
`timescale 1ns / 1ps
module bsd_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cmd_valid,
  input  bsd_pkg::cmd_t cmd,
  output logic          cmd_pop,
  output logic          out_valid,
  input  logic          out_ready,
  output bsd_pkg::res_t out_res
);
  import bsd_pkg::*;

  res_t       res_r, res_nxt;
  logic       ovalid_r, ovalid_nxt;
  logic [2:0] idx_r, idx_nxt;
  logic       tail_r, tail_nxt;
  logic       load;
  logic       final_main;

  assign load = !ovalid_r || out_ready;

  always_comb begin
    res_nxt = res_r;
    ovalid_nxt = ovalid_r;
    idx_nxt = idx_r;
    tail_nxt = tail_r;
    cmd_pop = 1'b0;
    final_main = ({1'b0, idx_r} == cmd.cnt - 4'd1);
    if (load) begin
      ovalid_nxt = cmd_valid;
      if (cmd_valid) begin
        if (tail_r) begin
          res_nxt = '0;
          res_nxt.kind = KIND_ERR;
          res_nxt.value = ERR_OFFSET;
          res_nxt.last = 1'b1;
          tail_nxt = 1'b0;
          cmd_pop = 1'b1;
          idx_nxt = '0;
        end else begin
          res_nxt = cmd.res;
          res_nxt.col = cmd.res.col + 13'(idx_r);
          case (cmd.mode)
            MODE_EXP4: res_nxt.value = (idx_r == 3'd0) ? {4'd0, cmd.res.value[7:4]} :
                                                         {4'd0, cmd.res.value[3:0]};
            MODE_EXP1: res_nxt.value = {7'd0, cmd.res.value[3'd7 - idx_r]};
            default:   res_nxt.value = cmd.res.value;
          endcase
          res_nxt.last = final_main && !cmd.tail_err;
          if (final_main) begin
            idx_nxt = '0;
            if (cmd.tail_err) tail_nxt = 1'b1;
            else cmd_pop = 1'b1;
          end else begin
            idx_nxt = idx_r + 3'd1;
          end
        end
      end
    end
  end

  assign out_valid = ovalid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      idx_r <= '0;
      tail_r <= 1'b0;
    end else begin
      ovalid_r <= ovalid_nxt;
      idx_r <= idx_nxt;
      tail_r <= tail_nxt;
    end
  end
endmodule

FILE: dv/tb_bmp_stream_decoder_unit.sv
// Self-checking testbench for the streaming BMP decoder, one randomized file per run.
`timescale 1ns / 1ps
module tb_bmp_stream_decoder_unit;
  import bsd_pkg::*;

  typedef enum logic [2:0] {
    PH_FILE_HDR, PH_INFO_HDR, PH_SKIP, PH_PALETTE, PH_GAP, PH_PIXELS, PH_DONE, PH_ERROR
  } dec_phase_e;

  typedef enum int {
    SC_GOOD, SC_WIDE, SC_MAGIC, SC_COMP, SC_DEPTH, SC_SIZE, SC_TRUNC, SC_OFFSET, SC_COLORS
  } scenario_e;

  typedef struct {
    logic [7:0] data;
    logic       eof;
  } file_byte_t;

  logic clk;
  logic rst_n;

  bsd_in_if  in_bus();
  bsd_out_if out_bus();

  bmp_stream_decoder_unit i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus)
  );

  file_byte_t file_bytes[$];
  res_t       expected_beats[$];
  res_t       step_beats[8];
  int         step_count;

  int unsigned total_bytes;
  int unsigned bytes_taken;
  int unsigned beats_seen;
  int unsigned errors;
  int unsigned burst_left;
  int unsigned gap_left;
  logic [15:0] stall_pattern;
  scenario_e   scenario;
  int unsigned hdr_bpp;

  // Decoder state mirrored by the predictor.
  dec_phase_e  st_phase;
  longint unsigned fpos;
  logic [31:0] shift_word;
  logic [31:0] pix_off;
  logic [31:0] hdr_left;
  logic [31:0] img_w;
  logic [31:0] img_h;
  logic        flip_off;
  logic [31:0] bpp;
  logic [31:0] pal_total;
  logic [31:0] pal_idx;
  logic [31:0] pal_cnt;
  logic [31:0] src_row;
  logic [31:0] row_byte;
  logic        comp_nz;
  logic        size_err;
  logic [31:0] used_colors;
  logic [7:0]  pal_blue;
  logic [7:0]  pal_green;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void emit(res_t r);
    if (step_count < 8) begin
      step_beats[step_count] = r;
      step_count++;
    end
  endfunction

  function automatic void raise_err(logic [7:0] code);
    res_t r;
    r = '0;
    r.kind = KIND_ERR;
    r.value = code;
    emit(r);
    st_phase = PH_ERROR;
  endfunction

  function automatic logic [31:0] row_bytes();
    if (bpp <= 8) return (img_w * bpp + 7) / 8;
    return img_w * (bpp / 8);
  endfunction

  function automatic void settle_phase();
    if (st_phase == PH_SKIP && hdr_left == 0) begin
      st_phase = PH_PALETTE;
      pal_idx = 0;
      pal_cnt = 0;
    end
    if (st_phase == PH_PALETTE && pal_idx >= pal_total) begin
      if (longint'(pix_off) < fpos) begin
        raise_err(ERR_OFFSET);
        return;
      end
      st_phase = PH_GAP;
    end
    if (st_phase == PH_GAP && fpos == longint'(pix_off)) begin
      st_phase = PH_PIXELS;
      src_row = 0;
      row_byte = 0;
    end
  endfunction

  function automatic void close_header();
    logic [31:0] ncolors;
    res_t r;
    ncolors = 0;
    r = '0;
    if (comp_nz) begin
      raise_err(ERR_COMP);
      return;
    end
    if (bpp == 0) begin
      raise_err(ERR_DEPTH);
      return;
    end
    if (size_err) begin
      raise_err(ERR_SIZE);
      return;
    end
    if (bpp <= 8) begin
      ncolors = (used_colors != 0) ? used_colors : (32'd1 << bpp);
      if (ncolors > 256) begin
        raise_err(ERR_SIZE);
        return;
      end
    end
    pal_total = ncolors;
    r.kind = KIND_INFO;
    r.width = img_w[11:0];
    r.height = img_h[11:0];
    r.depth_out = (bpp <= 8) ? 6'd8 : bpp[5:0];
    r.color_count = ncolors[8:0];
    emit(r);
    hdr_left = (hdr_left > 40) ? hdr_left - 40 : 0;
    st_phase = PH_SKIP;
  endfunction

  function automatic void header_field(logic [31:0] pos, logic [7:0] b);
    logic [31:0] w;
    logic [31:0] depth_field;
    shift_word = (shift_word >> 8) | (32'(b) << 24);
    w = shift_word;
    case (pos)
      13: begin
        pix_off = w;
        st_phase = PH_INFO_HDR;
      end
      17: hdr_left = w;
      21: begin
        img_w = w;
        if (w == 0 || w > 2048) size_err = 1'b1;
      end
      25: begin
        flip_off = w[31];
        img_h = flip_off ? (~w + 1) : w;
        if (img_h == 0 || img_h > 2048) size_err = 1'b1;
      end
      29: begin
        depth_field = (w >> 16) & 32'hFFFF;
        bpp = (depth_field inside {1, 4, 8, 24, 32}) ? depth_field : 0;
      end
      33: comp_nz = (w != 0);
      49: used_colors = w;
      53: close_header();
      default: ;
    endcase
  endfunction

  function automatic void pixel_step(logic [7:0] b);
    logic [31:0] srb;
    logic [31:0] padded;
    logic [31:0] x;
    int          per_byte;
    res_t        r;
    srb = row_bytes();
    padded = (srb + 3) & ~32'd3;
    r = '0;
    if (row_byte < srb) begin
      r.kind = KIND_PIX;
      r.row = flip_off ? src_row[10:0] : 11'(img_h - 1 - src_row);
      per_byte = (bpp == 4) ? 2 : (bpp == 1) ? 8 : 1;
      if (per_byte == 1) begin
        r.col = row_byte[12:0];
        r.value = b;
        emit(r);
      end else begin
        for (int i = 0; i < per_byte; i++) begin
          x = row_byte * per_byte + i;
          if (x >= img_w) break;
          r.col = x[12:0];
          if (per_byte == 2) r.value = (i != 0) ? (b & 8'h0F) : (b >> 4);
          else r.value = (b >> (7 - i)) & 8'd1;
          emit(r);
        end
      end
    end
    row_byte++;
    if (src_row + 1 >= img_h && row_byte >= srb) begin
      st_phase = PH_DONE;
    end else if (row_byte >= padded) begin
      row_byte = 0;
      src_row++;
    end
  endfunction

  function automatic void predict_byte(logic [7:0] b, logic eof);
    logic [31:0] pos;
    logic [1:0]  sub;
    res_t        r;
    step_count = 0;
    r = '0;
    if (st_phase == PH_DONE || st_phase == PH_ERROR) return;
    pos = fpos[31:0];
    case (st_phase)
      PH_FILE_HDR: begin
        if ((pos == 0 && b != 8'h42) || (pos == 1 && b != 8'h4D)) raise_err(ERR_MAGIC);
        else header_field(pos, b);
      end
      PH_INFO_HDR: header_field(pos, b);
      PH_SKIP: if (hdr_left > 0) hdr_left--;
      PH_PALETTE: begin
        sub = pal_cnt[1:0];
        if (sub == 0) pal_blue = b;
        else if (sub == 1) pal_green = b;
        else if (sub == 2) begin
          r.kind = KIND_PAL;
          r.col = pal_idx[12:0];
          r.red = b;
          r.green = pal_green;
          r.blue = pal_blue;
          emit(r);
        end else pal_idx++;
        pal_cnt++;
      end
      PH_PIXELS: pixel_step(b);
      default: ;
    endcase
    if (fpos < 64'h1_0000_0000) fpos++;
    if (st_phase inside {PH_SKIP, PH_PALETTE, PH_GAP}) settle_phase();
    if (eof && st_phase != PH_DONE && st_phase != PH_ERROR) begin
      step_count = 0;
      raise_err(ERR_TRUNCATED);
    end
    if (step_count > 0) step_beats[step_count - 1].last = 1'b1;
    for (int i = 0; i < step_count; i++) expected_beats.push_back(step_beats[i]);
  endfunction

  task automatic add_le(logic [31:0] v, int nbytes);
    file_byte_t fb;
    for (int i = 0; i < nbytes; i++) begin
      fb.data = v[8*i +: 8];
      fb.eof = 1'b0;
      file_bytes.push_back(fb);
    end
  endtask

  task automatic build_file();
    int unsigned w, h, depth, extra, hdr_field, ncol, used, gap, srb, padded, off, trim;
    logic [31:0] height_field;
    file_byte_t fb;
    scenario = scenario_e'($urandom_range(0, 12) > 8 ? SC_GOOD : $urandom_range(0, 8));
    case ($urandom_range(0, 4))
      0: depth = 1;
      1: depth = 4;
      2: depth = 8;
      3: depth = 24;
      default: depth = 32;
    endcase
    w = (depth <= 8) ? $urandom_range(1, 24) : $urandom_range(1, 7);
    h = $urandom_range(1, 5);
    if (scenario == SC_WIDE) begin
      depth = 1;
      w = 2048;
      h = 1;
    end
    used = 0;
    if (depth <= 8 && $urandom_range(0, 1)) used = $urandom_range(1, 12);
    if (depth == 8 && used == 0) used = $urandom_range(1, 20);
    if (scenario == SC_COLORS) begin
      depth = 8;
      used = $urandom_range(257, 300);
    end
    ncol = (depth <= 8) ? ((used != 0) ? used : (1 << depth)) : 0;
    if (ncol > 256) ncol = 0;
    if ($urandom_range(0, 3) == 0) begin
      hdr_field = 12;
      extra = 0;
    end else begin
      extra = $urandom_range(0, 6);
      hdr_field = 40 + extra;
    end
    gap = $urandom_range(0, 3);
    off = 54 + extra + 4 * ncol + gap;
    if (scenario == SC_OFFSET) off = 54 + extra + 4 * ncol - $urandom_range(1, 4);
    height_field = $urandom_range(0, 1) ? -h : h;
    hdr_bpp = depth;
    if (scenario == SC_DEPTH) hdr_bpp = $urandom_range(0, 1) ? 16 : $urandom_range(33, 65535);
    if (scenario == SC_SIZE) begin
      if ($urandom_range(0, 1)) w = $urandom_range(0, 1) ? 0 : $urandom_range(2049, 70000);
      else height_field = $urandom_range(0, 1) ? 0 : 32'd2049;
    end
    fb.eof = 1'b0;
    fb.data = 8'h42;
    file_bytes.push_back(fb);
    fb.data = 8'h4D;
    file_bytes.push_back(fb);
    if (scenario == SC_MAGIC) file_bytes[$urandom_range(0, 1)].data = $urandom_range(0, 255) ^ 8'h01;
    add_le($urandom, 4);
    add_le($urandom, 4);
    add_le(off, 4);
    add_le(hdr_field, 4);
    add_le(w, 4);
    add_le(height_field, 4);
    add_le(1, 2);
    add_le(hdr_bpp, 2);
    add_le((scenario == SC_COMP) ? $urandom_range(1, 3) : 0, 4);
    for (int i = 0; i < 3; i++) add_le($urandom, 4);
    add_le(used, 4);
    add_le($urandom, 4);
    for (int i = 0; i < extra + 4 * ncol + gap; i++) add_le($urandom, 1);
    srb = (depth <= 8) ? (w * depth + 7) / 8 : w * depth / 8;
    padded = (srb + 3) & ~3;
    for (int i = 0; i < padded * h && scenario != SC_SIZE; i++) add_le($urandom, 1);
    if (scenario == SC_TRUNC) begin
      trim = $urandom_range(padded - srb + 1, padded * h + 4);
      for (int i = 0; i < trim && file_bytes.size() > 2; i++) void'(file_bytes.pop_back());
    end else if ($urandom_range(0, 1)) begin
      for (int i = 0; i < padded - srb; i++) void'(file_bytes.pop_back());
    end
    file_bytes[$].eof = 1'b1;
    while (file_bytes.size() < 250) begin
      fb.data = $urandom;
      fb.eof = $urandom_range(0, 1);
      file_bytes.push_back(fb);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.data_byte <= '0;
      in_bus.end_of_file <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        predict_byte(in_bus.data_byte, in_bus.end_of_file);
        bytes_taken++;
      end
      if (!(in_bus.valid && !in_bus.ready)) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_bus.valid <= 1'b0;
        end else if (file_bytes.size() > 0) begin
          in_bus.data_byte <= file_bytes[0].data;
          in_bus.end_of_file <= file_bytes[0].eof;
          void'(file_bytes.pop_front());
          in_bus.valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
      stall_pattern <= 16'hFFFF;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got = '{out_bus.kind, out_bus.row, out_bus.col, out_bus.value, out_bus.red,
                out_bus.green, out_bus.blue, out_bus.width, out_bus.height,
                out_bus.depth_out, out_bus.color_count, out_bus.last};
        beats_seen++;
        if (expected_beats.size() == 0) begin
          errors++;
          if (errors <= 10) $display("Unexpected result beat %p", got);
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            errors++;
            if (errors <= 10) $display("Result beat %0d mismatch: expected %p, got %p",
                                       beats_seen, want, got);
          end
        end
      end
      if ($urandom_range(0, 31) == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pattern <= 16'hFFFF;
          1: stall_pattern <= $urandom;
          default: stall_pattern <= 16'h8421;
        endcase
      end else begin
        stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      end
      out_bus.ready <= stall_pattern[0];
    end
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.data_byte = '0;
    in_bus.end_of_file = 1'b0;
    out_bus.ready = 1'b0;
    rst_n = 1'b0;
    st_phase = PH_FILE_HDR;
    fpos = 0;
    {shift_word, pix_off, hdr_left, img_w, img_h, bpp} = '0;
    {pal_total, pal_idx, pal_cnt, src_row, row_byte, used_colors} = '0;
    {flip_off, comp_nz, size_err, pal_blue, pal_green} = '0;
    bytes_taken = 0;
    beats_seen = 0;
    errors = 0;
    build_file();
    total_bytes = file_bytes.size();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    wait (bytes_taken == total_bytes);
    wait (expected_beats.size() == 0);
    repeat (40) @(posedge clk);
    $display("Decoded one file (scenario %s, header depth %0d): %0d bytes in, %0d beats out.",
             scenario.name(), hdr_bpp, total_bytes, beats_seen);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0d mismatching beats", errors);
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Timeout with %0d beats still expected", expected_beats.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
